/* rtl/ipv4rhc_pkg.sv */
// Package for the IPv4 receive header check unit.
// Holds the verdict codes, register indexes and header constants; no dependencies.
package ipv4rhc_pkg;

    typedef enum logic [3:0] {
        VERDICT_ACCEPT   = 4'd0,
        VERDICT_SHORT    = 4'd1,
        VERDICT_VERSION  = 4'd2,
        VERDICT_HLEN     = 4'd3,
        VERDICT_TOTAL    = 4'd4,
        VERDICT_CHECKSUM = 4'd5,
        VERDICT_FRAGMENT = 4'd6,
        VERDICT_NO_IFACE = 4'd7,
        VERDICT_NOT_OURS = 4'd8
    } verdict_t;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOCAL_ADDRESS      = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTED_BROADCAST = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTERFACE_PRESENT  = 2'd2;

    localparam logic [15:0] HDR_MIN        = 16'd20;
    localparam logic [15:0] COUNT_MAX      = 16'hffff;
    localparam logic [15:0] CHECKSUM_GOOD  = 16'hffff;
    localparam logic [15:0] MORE_FRAGMENTS = 16'h2000;
    localparam logic [15:0] FRAG_OFFSET    = 16'h1fff;
    localparam logic [31:0] BCAST_ALL      = 32'hffffffff;
    localparam logic [3:0]  IPV4_VERSION   = 4'd4;

    localparam logic [15:0] POS_VERSION_IHL = 16'd0;
    localparam logic [15:0] POS_TOTAL_HI    = 16'd2;
    localparam logic [15:0] POS_TOTAL_LO    = 16'd3;
    localparam logic [15:0] POS_FLAGS_HI    = 16'd6;
    localparam logic [15:0] POS_FLAGS_LO    = 16'd7;
    localparam logic [15:0] POS_PROTOCOL    = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST   = 16'd12;
    localparam logic [15:0] POS_SRC_LAST    = 16'd15;
    localparam logic [15:0] POS_DST_FIRST   = 16'd16;
    localparam logic [15:0] POS_DST_LAST    = 16'd19;

endpackage

/* rtl/ipv4rhc_if.sv */
// Valid/ready channel interfaces for the IPv4 receive header check unit.
// Depends on ipv4rhc_pkg for the verdict type.
interface ipv4rhc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface ipv4rhc_result_if;
    logic                  valid;
    logic                  ready;
    ipv4rhc_pkg::verdict_t verdict;
    logic [7:0]            protocol_number;
    logic [5:0]            header_length;
    logic [15:0]           payload_length;
    logic [31:0]           source_address;
    logic [31:0]           destination_address;

    modport source (
        output valid, output verdict, output protocol_number, output header_length,
        output payload_length, output source_address, output destination_address,
        input ready
    );
    modport sink (
        input valid, input verdict, input protocol_number, input header_length,
        input payload_length, input source_address, input destination_address,
        output ready
    );
endinterface

/* rtl/ipv4_receive_header_check_unit.sv */
// A byte is registered at input, and the verdict of a packet is loaded into the result
// register when its last byte is processed, which waits while an earlier result is held.
// Throughput: one byte per cycle but for that wait; the single header-state update
// and checksum add between the input register and the result register set this rate.
// Reset: rst_n clears the configuration registers, the packet state and both valid flags.
// Depends on ipv4rhc_pkg and the channel interfaces in ipv4rhc_if.sv.
module ipv4_receive_header_check_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    ipv4rhc_byte_if.sink                             rx,
    ipv4rhc_result_if.source                         result,
    input  logic                                     cfg_we,
    input  logic [ipv4rhc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ipv4rhc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    logic [31:0] local_address_reg;
    logic [31:0] directed_broadcast_reg;
    logic        interface_present_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [15:0] flags_offset_reg, flags_offset_next;
    logic [7:0]  proto_field_reg, proto_field_next;
    logic [31:0] src_field_reg, src_field_next;
    logic [31:0] dst_field_reg, dst_field_next;
    logic [15:0] checksum_sum_reg, checksum_sum_next;
    logic [7:0]  held_high_byte_reg, held_high_byte_next;

    logic                  out_valid_reg;
    ipv4rhc_pkg::verdict_t verdict_reg, verdict_next;
    logic [7:0]            protocol_reg;
    logic [5:0]            header_length_reg, header_length_next;
    logic [15:0]           payload_length_reg, payload_length_next;
    logic [31:0]           source_reg;
    logic [31:0]           destination_reg;

    logic        proc_go;
    logic        proc_fire;
    logic        emit;
    logic [16:0] sum_wide;
    logic [15:0] sum_folded;
    logic [15:0] pos;

    // A byte without the last mark never needs the result register.
    assign proc_go   = !in_last_reg || !out_valid_reg || result.ready;
    assign proc_fire = in_valid_reg && proc_go;
    assign emit      = proc_fire && in_last_reg;
    assign rx.ready  = !in_valid_reg || proc_go;
    assign pos       = byte_count_reg;

    always_comb
    begin
        version_ihl_next    = version_ihl_reg;
        total_length_next   = total_length_reg;
        flags_offset_next   = flags_offset_reg;
        proto_field_next    = proto_field_reg;
        src_field_next      = src_field_reg;
        dst_field_next      = dst_field_reg;
        checksum_sum_next   = checksum_sum_reg;
        held_high_byte_next = held_high_byte_reg;

        if (pos == ipv4rhc_pkg::POS_VERSION_IHL)
        begin
            version_ihl_next = in_byte_reg;
        end
        else if (pos == ipv4rhc_pkg::POS_TOTAL_HI || pos == ipv4rhc_pkg::POS_TOTAL_LO)
        begin
            total_length_next = {total_length_reg[7:0], in_byte_reg};
        end
        else if (pos == ipv4rhc_pkg::POS_FLAGS_HI || pos == ipv4rhc_pkg::POS_FLAGS_LO)
        begin
            flags_offset_next = {flags_offset_reg[7:0], in_byte_reg};
        end
        else if (pos == ipv4rhc_pkg::POS_PROTOCOL)
        begin
            proto_field_next = in_byte_reg;
        end
        else if (pos >= ipv4rhc_pkg::POS_SRC_FIRST && pos <= ipv4rhc_pkg::POS_SRC_LAST)
        begin
            src_field_next = {src_field_reg[23:0], in_byte_reg};
        end
        else if (pos >= ipv4rhc_pkg::POS_DST_FIRST && pos <= ipv4rhc_pkg::POS_DST_LAST)
        begin
            dst_field_next = {dst_field_reg[23:0], in_byte_reg};
        end

        header_length_next = {version_ihl_next[3:0], 2'b00};

        sum_wide   = {1'b0, checksum_sum_reg} + {1'b0, held_high_byte_reg, in_byte_reg};
        sum_folded = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

        if (pos < {10'd0, header_length_next})
        begin
            if (!pos[0])
            begin
                held_high_byte_next = in_byte_reg;
            end
            else
            begin
                checksum_sum_next = sum_folded;
            end
        end

        byte_count_next = (byte_count_reg < ipv4rhc_pkg::COUNT_MAX)
                        ? byte_count_reg + 16'd1 : byte_count_reg;

        if (byte_count_next < ipv4rhc_pkg::HDR_MIN)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_SHORT;
        end
        else if (version_ihl_next[7:4] != ipv4rhc_pkg::IPV4_VERSION)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_VERSION;
        end
        else if (byte_count_next < {10'd0, header_length_next})
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_HLEN;
        end
        else if (byte_count_next < total_length_next)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_TOTAL;
        end
        else if (checksum_sum_next != ipv4rhc_pkg::CHECKSUM_GOOD)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_CHECKSUM;
        end
        else if ((flags_offset_next & (ipv4rhc_pkg::MORE_FRAGMENTS
                                       | ipv4rhc_pkg::FRAG_OFFSET)) != 16'd0)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_FRAGMENT;
        end
        else if (!interface_present_reg)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_NO_IFACE;
        end
        else if (dst_field_next != local_address_reg
                 && dst_field_next != ipv4rhc_pkg::BCAST_ALL
                 && dst_field_next != directed_broadcast_reg)
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_NOT_OURS;
        end
        else
        begin
            verdict_next = ipv4rhc_pkg::VERDICT_ACCEPT;
        end

        payload_length_next = (total_length_next >= {10'd0, header_length_next})
                            ? total_length_next - {10'd0, header_length_next} : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg      <= '0;
            directed_broadcast_reg <= '0;
            interface_present_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ipv4rhc_pkg::REG_LOCAL_ADDRESS:      local_address_reg <= cfg_data[31:0];
                ipv4rhc_pkg::REG_DIRECTED_BROADCAST: directed_broadcast_reg <= cfg_data[31:0];
                ipv4rhc_pkg::REG_INTERFACE_PRESENT:  interface_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.packet_byte;
            in_last_reg <= rx.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg     <= '0;
            version_ihl_reg    <= '0;
            total_length_reg   <= '0;
            flags_offset_reg   <= '0;
            proto_field_reg    <= '0;
            src_field_reg      <= '0;
            dst_field_reg      <= '0;
            checksum_sum_reg   <= '0;
            held_high_byte_reg <= '0;
        end
        else if (emit)
        begin
            byte_count_reg     <= '0;
            version_ihl_reg    <= '0;
            total_length_reg   <= '0;
            flags_offset_reg   <= '0;
            proto_field_reg    <= '0;
            src_field_reg      <= '0;
            dst_field_reg      <= '0;
            checksum_sum_reg   <= '0;
            held_high_byte_reg <= '0;
        end
        else if (proc_fire)
        begin
            byte_count_reg     <= byte_count_next;
            version_ihl_reg    <= version_ihl_next;
            total_length_reg   <= total_length_next;
            flags_offset_reg   <= flags_offset_next;
            proto_field_reg    <= proto_field_next;
            src_field_reg      <= src_field_next;
            dst_field_reg      <= dst_field_next;
            checksum_sum_reg   <= checksum_sum_next;
            held_high_byte_reg <= held_high_byte_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            verdict_reg        <= verdict_next;
            protocol_reg       <= proto_field_next;
            header_length_reg  <= header_length_next;
            payload_length_reg <= payload_length_next;
            source_reg         <= src_field_next;
            destination_reg    <= dst_field_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.verdict             = verdict_reg;
    assign result.protocol_number     = protocol_reg;
    assign result.header_length       = header_length_reg;
    assign result.payload_length      = payload_length_reg;
    assign result.source_address      = source_reg;
    assign result.destination_address = destination_reg;

endmodule

/* sim/ipv4_receive_header_check_unit_test.sv */
// Self-checking testbench for ipv4_receive_header_check_unit: IPv4 packets go in as byte beats
// and every verdict beat is compared with a header-check predictor kept inside the bench.
// Depends on ipv4rhc_pkg, the channel interfaces in ipv4rhc_if.sv and the unit itself.
module ipv4_receive_header_check_unit_test;

    localparam logic [ipv4rhc_pkg::CFG_INDEX_WIDTH-1:0] REG_UNASSIGNED = 2'd3;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RANDOM_BYTES    = 960;
    localparam int RANDOM_PACKETS  = 24;
    localparam int PHASES          = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wire_beat_t;

    typedef struct {
        ipv4rhc_pkg::verdict_t verdict;
        logic [7:0]            protocol_number;
        logic [5:0]            header_length;
        logic [15:0]           payload_length;
        logic [31:0]           source_address;
        logic [31:0]           destination_address;
    } header_verdict_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} stall_pattern_t;

    logic                                    clk = 1'b0;
    logic                                    rst_n;
    logic                                    cfg_we;
    logic [ipv4rhc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [ipv4rhc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    ipv4rhc_byte_if   rx_ch ();
    ipv4rhc_result_if res_ch ();

    wire_beat_t      pending_beats[$];
    header_verdict_t awaited_verdicts[$];
    logic [7:0]      frame[$];
    wire_beat_t      next_beat;
    header_verdict_t due_verdict;

    logic [31:0] iface_local = 32'd0;
    logic [31:0] iface_bcast = 32'd0;
    logic        iface_up = 1'b0;

    logic [15:0] seen_count = 16'd0;
    logic [7:0]  vihl_field = 8'd0;
    logic [15:0] total_field = 16'd0;
    logic [15:0] flags_field = 16'd0;
    logic [7:0]  proto_field = 8'd0;
    logic [31:0] src_field = 32'd0;
    logic [31:0] dst_field = 32'd0;
    logic [15:0] header_sum = 16'd0;
    logic [7:0]  held_byte = 8'd0;

    int failures = 0;
    int cycles = 0;
    int burst_left = 0;
    int idle_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_granted = 0;
    int mode_left = 0;
    int phase_bytes = 0;
    int phase_packets = 0;
    int phase;
    stall_pattern_t stall_mode = READY_ALWAYS;

    ipv4_receive_header_check_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    task clear_packet_state;
        seen_count = 16'd0;
        vihl_field = 8'd0;
        total_field = 16'd0;
        flags_field = 16'd0;
        proto_field = 8'd0;
        src_field = 32'd0;
        dst_field = 32'd0;
        header_sum = 16'd0;
        held_byte = 8'd0;
    endtask

    task automatic track_packet_byte(input logic [7:0] b, input logic last);
        logic [15:0] pos;
        logic [5:0] hl;
        logic [16:0] s;
        header_verdict_t v;
        pos = seen_count;
        if (pos == ipv4rhc_pkg::POS_VERSION_IHL)
            vihl_field = b;
        else if (pos == ipv4rhc_pkg::POS_TOTAL_HI || pos == ipv4rhc_pkg::POS_TOTAL_LO)
            total_field = {total_field[7:0], b};
        else if (pos == ipv4rhc_pkg::POS_FLAGS_HI || pos == ipv4rhc_pkg::POS_FLAGS_LO)
            flags_field = {flags_field[7:0], b};
        else if (pos == ipv4rhc_pkg::POS_PROTOCOL)
            proto_field = b;
        else if (pos >= ipv4rhc_pkg::POS_SRC_FIRST && pos <= ipv4rhc_pkg::POS_SRC_LAST)
            src_field = {src_field[23:0], b};
        else if (pos >= ipv4rhc_pkg::POS_DST_FIRST && pos <= ipv4rhc_pkg::POS_DST_LAST)
            dst_field = {dst_field[23:0], b};
        hl = {vihl_field[3:0], 2'b00};
        if (pos < {10'd0, hl})
        begin
            if (!pos[0])
                held_byte = b;
            else
            begin
                s = {1'b0, header_sum} + {1'b0, held_byte, b};
                if (s[16])
                    s = {1'b0, s[15:0]} + 17'd1;
                header_sum = s[15:0];
            end
        end
        if (seen_count != ipv4rhc_pkg::COUNT_MAX)
            seen_count = seen_count + 16'd1;
        if (last)
        begin
            if (seen_count < ipv4rhc_pkg::HDR_MIN)
                v.verdict = ipv4rhc_pkg::VERDICT_SHORT;
            else if (vihl_field[7:4] != ipv4rhc_pkg::IPV4_VERSION)
                v.verdict = ipv4rhc_pkg::VERDICT_VERSION;
            else if (seen_count < {10'd0, hl})
                v.verdict = ipv4rhc_pkg::VERDICT_HLEN;
            else if (seen_count < total_field)
                v.verdict = ipv4rhc_pkg::VERDICT_TOTAL;
            else if (header_sum != ipv4rhc_pkg::CHECKSUM_GOOD)
                v.verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
            else if ((flags_field & (ipv4rhc_pkg::MORE_FRAGMENTS
                                     | ipv4rhc_pkg::FRAG_OFFSET)) != 16'd0)
                v.verdict = ipv4rhc_pkg::VERDICT_FRAGMENT;
            else if (!iface_up)
                v.verdict = ipv4rhc_pkg::VERDICT_NO_IFACE;
            else if (dst_field != iface_local && dst_field != ipv4rhc_pkg::BCAST_ALL &&
                     dst_field != iface_bcast)
                v.verdict = ipv4rhc_pkg::VERDICT_NOT_OURS;
            else
                v.verdict = ipv4rhc_pkg::VERDICT_ACCEPT;
            v.protocol_number = proto_field;
            v.header_length = hl;
            v.payload_length = (total_field >= {10'd0, hl})
                             ? total_field - {10'd0, hl} : 16'd0;
            v.source_address = src_field;
            v.destination_address = dst_field;
            awaited_verdicts.push_back(v);
            clear_packet_state();
        end
    endtask

    // The header gets a valid checksum over its first IHL*4 bytes; the word patched to
    // make it valid sits inside that range, so short headers may lose their total length.
    task automatic build_frame(input logic [3:0] ver, input logic [3:0] ihl, input int payload,
                               input int total_len, input logic [15:0] flags,
                               input logic [31:0] dst);
        int hl;
        int body;
        int fix;
        int i;
        logic [16:0] s;
        hl = ihl * 4;
        body = (hl > 20) ? hl : 20;
        frame.delete();
        for (i = 0; i < body + payload; i++)
            frame.push_back(8'($urandom_range(0, 255)));
        frame[0] = {ver, ihl};
        frame[2] = total_len[15:8];
        frame[3] = total_len[7:0];
        frame[6] = flags[15:8];
        frame[7] = flags[7:0];
        for (i = 0; i < 4; i++)
            frame[16 + i] = dst[31 - 8 * i -: 8];
        if (hl > 0)
        begin
            fix = (hl >= 12) ? 10 : ((hl >= 8) ? 4 : 2);
            frame[fix] = 8'd0;
            frame[fix + 1] = 8'd0;
            s = 17'd0;
            for (i = 0; i < hl; i += 2)
            begin
                s = s + {1'b0, frame[i], frame[i + 1]};
                if (s[16])
                    s = {1'b0, s[15:0]} + 17'd1;
            end
            frame[fix] = ~s[15:8];
            frame[fix + 1] = ~s[7:0];
        end
    endtask

    task automatic fill_frame(input int n, input bit scatter, input logic [7:0] value);
        int i;
        frame.delete();
        for (i = 0; i < n; i++)
            frame.push_back(scatter ? 8'($urandom_range(0, 255)) : value);
    endtask

    task automatic send_frame(input int count);
        int i;
        while (frame.size() < count)
            frame.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < count; i++)
            pending_beats.push_back(wire_beat_t'{frame[i], i == count - 1});
        phase_bytes += count;
        phase_packets++;
    endtask

    function automatic logic [31:0] pick_destination();
        case ($urandom_range(0, 3))
            0: return iface_local;
            1: return ipv4rhc_pkg::BCAST_ALL;
            2: return iface_bcast;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_packet;
        int pick;
        int payload;
        int tot;
        int spot;
        logic [3:0] ihl;
        logic [3:0] ver;
        logic [15:0] fl;
        pick = $urandom_range(0, 99);
        ver = ipv4rhc_pkg::IPV4_VERSION;
        ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        payload = $urandom_range(0, 24);
        fl = 16'($urandom_range(0, 3)) << 14;
        if (pick >= 55 && pick < 63)
            fl = fl | (($urandom_range(0, 1) == 0) ? ipv4rhc_pkg::MORE_FRAGMENTS
                                                   : 16'($urandom_range(1, 8191)));
        if (pick >= 63 && pick < 69)
        begin
            ver = 4'($urandom_range(0, 14));
            if (ver >= ipv4rhc_pkg::IPV4_VERSION)
                ver = ver + 4'd1;
        end
        if (pick >= 69 && pick < 75)
            ihl = 4'($urandom_range(0, 4));
        if (pick >= 95)
        begin
            fill_frame($urandom_range(1, 48), 1'b1, 8'h00);
            if ($urandom_range(0, 1) == 0)
                frame[0] = {ipv4rhc_pkg::IPV4_VERSION, 4'd5};
            send_frame(frame.size());
        end
        else
        begin
            tot = ihl * 4 + payload;
            if (pick >= 75 && pick < 81)
                tot = $urandom_range(0, ihl * 4 - 1);
            build_frame(ver, ihl, payload, tot, fl, pick_destination());
            if (pick >= 81 && pick < 88)
            begin
                spot = $urandom_range(8, 19);
                frame[spot] = frame[spot] ^ 8'(1 << $urandom_range(0, 7));
            end
            if (pick >= 88)
                send_frame($urandom_range(1, frame.size() - 1));
            else
                send_frame(frame.size() + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
        end
    endtask

    task wait_until_drained;
        @(negedge clk);
        while (pending_beats.size() != 0 || rx_ch.valid || awaited_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_register(input logic [ipv4rhc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                        input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            ipv4rhc_pkg::REG_LOCAL_ADDRESS: iface_local = value;
            ipv4rhc_pkg::REG_DIRECTED_BROADCAST: iface_bcast = value;
            ipv4rhc_pkg::REG_INTERFACE_PRESENT: iface_up = value[0];
            default: ;
        endcase
    endtask

    task configure_interface(input logic [31:0] local_a, input logic [31:0] bcast_a,
                             input logic up);
        logic [31:0] junk;
        wait_until_drained();
        junk = $urandom;
        junk[0] = up;
        write_register(ipv4rhc_pkg::REG_LOCAL_ADDRESS, local_a);
        write_register(ipv4rhc_pkg::REG_DIRECTED_BROADCAST, bcast_a);
        write_register(ipv4rhc_pkg::REG_INTERFACE_PRESENT, junk);
        write_register(REG_UNASSIGNED, $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task random_phase(input int byte_goal, input int packet_goal);
        phase_bytes = 0;
        phase_packets = 0;
        while (phase_bytes < byte_goal || phase_packets < packet_goal)
            random_packet();
    endtask

    // Sender: every byte beat accepted here also feeds the predictor.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            burst_left = 0;
            idle_left = 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
                track_packet_byte(rx_ch.packet_byte, rx_ch.last_byte);
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    rx_ch.valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    next_beat = pending_beats.pop_front();
                    rx_ch.valid <= 1'b1;
                    rx_ch.packet_byte <= next_beat.data;
                    rx_ch.last_byte <= next_beat.last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each verdict beat and shapes ready, including the long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (awaited_verdicts.size() == 0)
                begin
                    $error("result beat arrived with no verdict awaited");
                    failures++;
                end
                else
                begin
                    due_verdict = awaited_verdicts.pop_front();
                    if (res_ch.verdict !== due_verdict.verdict)
                    begin
                        $error("verdict: expected %0d, got %0d",
                               due_verdict.verdict, res_ch.verdict);
                        failures++;
                    end
                    if (res_ch.protocol_number !== due_verdict.protocol_number)
                    begin
                        $error("protocol_number: expected %0d, got %0d",
                               due_verdict.protocol_number, res_ch.protocol_number);
                        failures++;
                    end
                    if (res_ch.header_length !== due_verdict.header_length)
                    begin
                        $error("header_length: expected %0d, got %0d",
                               due_verdict.header_length, res_ch.header_length);
                        failures++;
                    end
                    if (res_ch.payload_length !== due_verdict.payload_length)
                    begin
                        $error("payload_length: expected %0d, got %0d",
                               due_verdict.payload_length, res_ch.payload_length);
                        failures++;
                    end
                    if (res_ch.source_address !== due_verdict.source_address)
                    begin
                        $error("source_address: expected %h, got %h",
                               due_verdict.source_address, res_ch.source_address);
                        failures++;
                    end
                    if (res_ch.destination_address !== due_verdict.destination_address)
                    begin
                        $error("destination_address: expected %h, got %h",
                               due_verdict.destination_address, res_ch.destination_address);
                        failures++;
                    end
                end
            end
            if (hold_granted != hold_requests)
            begin
                hold_granted = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0)
            begin
                stall_mode = stall_pattern_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    READY_ALWAYS: res_ch.ready <= 1'b1;
                    READY_COIN: res_ch.ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: res_ch.ready <= (mode_left % 4 == 0);
                    default: res_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ipv4_receive_header_check_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ipv4rhc_pkg::REG_LOCAL_ADDRESS;
        cfg_data = 32'd0;
        rx_ch.valid = 1'b0;
        rx_ch.packet_byte = 8'd0;
        rx_ch.last_byte = 1'b0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset configuration no interface is bound.
        fill_frame(1, 1'b0, 8'hff);
        send_frame(1);
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 8, 28, 16'h0000, 32'd0);
        send_frame(frame.size());

        configure_interface($urandom, $urandom, 1'b1);
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 4, 24, 16'h0000, iface_local);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 0, 20, 16'h0000, ipv4rhc_pkg::BCAST_ALL);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 2, 22, 16'h0000, iface_bcast);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 0, 20, 16'h0000, $urandom);
        send_frame(frame.size());
        build_frame(4'd6, 4'd5, 0, 20, 16'h0000, iface_local);
        send_frame(frame.size());
        // A header length of zero sums nothing and so fails the checksum.
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd0, 4, 4, 16'h0000, iface_local);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd15, 0, 60, 16'h0000, iface_local);
        send_frame(40);
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 20, 40, 16'h0000, iface_local);
        send_frame(30);
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 0, 20, 16'h0000, iface_local);
        frame[10] = frame[10] ^ 8'h01;
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 0, 20, ipv4rhc_pkg::MORE_FRAGMENTS,
                    iface_local);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 0, 20, ipv4rhc_pkg::FRAG_OFFSET,
                    iface_local);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd8, 0, 12, 16'h0000, iface_local);
        send_frame(frame.size());
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd3, 6, 18, 16'h0000, iface_local);
        send_frame(frame.size());
        fill_frame(20, 1'b0, 8'h00);
        send_frame(20);
        fill_frame(20, 1'b0, 8'hff);
        send_frame(20);
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd5, 0, 20, 16'h0000, iface_local);
        send_frame(19);
        build_frame(ipv4rhc_pkg::IPV4_VERSION, 4'd15, 4, 64, 16'h0000, iface_local);
        send_frame(frame.size());

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: configure_interface($urandom, $urandom, 1'b1);
                1: configure_interface(32'h00000000, 32'hffffffff, 1'b1);
                2: configure_interface(32'hffffffff, 32'h00000000, 1'b0);
                default: configure_interface($urandom, $urandom, 1'b1);
            endcase
            random_phase(RANDOM_BYTES / PHASES, RANDOM_PACKETS / PHASES);
            if (phase == 1)
                hold_requests++;
        end

        wait_until_drained();
        if (failures == 0)
            $display("ipv4_receive_header_check_unit regression: pass");
        else
            $display("ipv4_receive_header_check_unit regression: fail");
        $finish;
    end

endmodule
